@@ hw/rtl/aoc_pkg.sv @@
// Shared types, constants and stream packing widths for the box overlap contact core.
`default_nettype none

package aoc_pkg;

    // Field widths
    localparam int COORD_W      = 31;   // signed Q15.16 center
    localparam int EXTENT_W     = 31;   // unsigned Q15.16 full size
    localparam int BOUND_W      = 33;   // center +/- half size
    localparam int DIST_W       = 34;   // difference of two bounds
    localparam int DEPTH_W      = 31;
    localparam int AXIS_W       = 2;
    localparam int CONTACT_W    = 32;

    localparam int COORD_BITS_DEF = 32;

    // Stream packing
    localparam int N_IN_FIELDS  = 12;
    localparam int IN_USED_W    = N_IN_FIELDS * COORD_W;
    localparam int S_TDATA_W    = ((IN_USED_W + 7) / 8) * 8;
    localparam int OUT_USED_W   = DEPTH_W + AXIS_W + 1 + 3 * CONTACT_W;
    localparam int M_TDATA_W    = ((OUT_USED_W + 7) / 8) * 8;

    typedef logic signed [COORD_W-1:0]  coord_t;
    typedef logic        [EXTENT_W-1:0] extent_t;
    typedef logic signed [BOUND_W-1:0]  bound_t;
    typedef logic signed [DIST_W-1:0]   dist_t;

    typedef enum logic [AXIS_W-1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    // One box pair as it enters the pipe
    typedef struct packed {
        coord_t  [2:0] ca;
        extent_t [2:0] sa;
        coord_t  [2:0] cb;
        extent_t [2:0] sb;
    } box_t;

    // After bounds stage
    typedef struct packed {
        coord_t [2:0] ca;
        coord_t [2:0] cb;
        bound_t [2:0] lo_a;
        bound_t [2:0] hi_a;
        bound_t [2:0] lo_b;
        bound_t [2:0] hi_b;
    } s1_t;

    // After overlap stage
    typedef struct packed {
        logic          hit;
        logic   [2:0]  pos;
        dist_t  [2:0]  ov;
        coord_t [2:0]  ca;
        bound_t [2:0]  lo_a;
        bound_t [2:0]  hi_a;
    } s2_t;

    // Scalar result fields
    typedef struct packed {
        logic               hit;
        logic [DEPTH_W-1:0] depth;
        axis_t              axis;
        logic               neg;
    } res_t;

endpackage

`default_nettype wire

@@ hw/rtl/aoc_bounds.sv @@
// Pipeline stage 1: per-axis min and max of both boxes.
`default_nettype none

module aoc_bounds (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire aoc_pkg::box_t in_box,
    output logic               out_valid,
    input  wire logic          out_ready,
    output aoc_pkg::s1_t       out_s1
);

    logic         valid_reg;
    aoc_pkg::s1_t s1_reg;
    aoc_pkg::s1_t s1_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_s1    = s1_reg;

    always_comb begin
        aoc_pkg::bound_t ha;
        aoc_pkg::bound_t hb;
        aoc_pkg::bound_t ca;
        aoc_pkg::bound_t cb;
        for (int k = 0; k < 3; k++) begin
            // half size is a floor shift
            ha = $signed({3'b000, in_box.sa[k][aoc_pkg::EXTENT_W-1:1]});
            hb = $signed({3'b000, in_box.sb[k][aoc_pkg::EXTENT_W-1:1]});
            ca = aoc_pkg::BOUND_W'($signed(in_box.ca[k]));
            cb = aoc_pkg::BOUND_W'($signed(in_box.cb[k]));
            s1_next.ca[k]   = in_box.ca[k];
            s1_next.cb[k]   = in_box.cb[k];
            s1_next.lo_a[k] = ca - ha;
            s1_next.hi_a[k] = ca + ha;
            s1_next.lo_b[k] = cb - hb;
            s1_next.hi_b[k] = cb + hb;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            s1_reg <= s1_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/aoc_overlap.sv @@
// Pipeline stage 2: per-axis hit test, overlap depth and direction.
`default_nettype none

module aoc_overlap (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire aoc_pkg::s1_t in_s1,
    output logic              out_valid,
    input  wire logic         out_ready,
    output aoc_pkg::s2_t      out_s2
);

    logic         valid_reg;
    aoc_pkg::s2_t s2_reg;
    aoc_pkg::s2_t s2_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_s2    = s2_reg;

    always_comb begin
        aoc_pkg::dist_t d1;
        aoc_pkg::dist_t d2;
        logic [2:0]     axis_hit;
        for (int k = 0; k < 3; k++) begin
            axis_hit[k] = ($signed(in_s1.lo_a[k]) <= $signed(in_s1.hi_b[k])) &&
                          ($signed(in_s1.hi_a[k]) >= $signed(in_s1.lo_b[k]));
            d1 = aoc_pkg::DIST_W'($signed(in_s1.hi_a[k])) -
                 aoc_pkg::DIST_W'($signed(in_s1.lo_b[k]));
            d2 = aoc_pkg::DIST_W'($signed(in_s1.hi_b[k])) -
                 aoc_pkg::DIST_W'($signed(in_s1.lo_a[k]));
            s2_next.ov[k]   = ($signed(d1) < $signed(d2)) ? d1 : d2;
            s2_next.pos[k]  = $signed(in_s1.cb[k]) > $signed(in_s1.ca[k]);
            s2_next.ca[k]   = in_s1.ca[k];
            s2_next.lo_a[k] = in_s1.lo_a[k];
            s2_next.hi_a[k] = in_s1.hi_a[k];
        end
        s2_next.hit = &axis_hit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            s2_reg <= s2_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/aoc_select.sv @@
// Pipeline stage 3: least-overlap axis pick, contact point and output register.
`default_nettype none

module aoc_select #(
    parameter int COORD_BITS = aoc_pkg::COORD_BITS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire aoc_pkg::s2_t                    in_s2,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output aoc_pkg::res_t                        out_res,
    output logic signed [aoc_pkg::CONTACT_W-1:0] contact_x,
    output logic signed [aoc_pkg::CONTACT_W-1:0] contact_y,
    output logic signed [aoc_pkg::CONTACT_W-1:0] contact_z
);

    logic                         valid_reg;
    aoc_pkg::res_t                res_reg;
    aoc_pkg::res_t                res_next;
    logic signed [COORD_BITS-1:0] contact_reg  [3];
    logic signed [COORD_BITS-1:0] contact_next [3];

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;
    assign contact_x = aoc_pkg::CONTACT_W'(contact_reg[0]);
    assign contact_y = aoc_pkg::CONTACT_W'(contact_reg[1]);
    assign contact_z = aoc_pkg::CONTACT_W'(contact_reg[2]);

    always_comb begin
        logic            c10;
        logic            c20;
        logic            c21;
        aoc_pkg::axis_t  axis_sel;
        aoc_pkg::dist_t  ov_sel;
        logic            pos_sel;
        aoc_pkg::bound_t face;
        aoc_pkg::bound_t cval;
        // pairwise compares in parallel; ties keep the lower axis
        c10 = $signed(in_s2.ov[1]) < $signed(in_s2.ov[0]);
        c20 = $signed(in_s2.ov[2]) < $signed(in_s2.ov[0]);
        c21 = $signed(in_s2.ov[2]) < $signed(in_s2.ov[1]);
        if (c10) begin
            axis_sel = c21 ? aoc_pkg::AXIS_Z : aoc_pkg::AXIS_Y;
        end else begin
            axis_sel = c20 ? aoc_pkg::AXIS_Z : aoc_pkg::AXIS_X;
        end
        case (axis_sel)
            aoc_pkg::AXIS_Y: begin
                ov_sel  = in_s2.ov[1];
                pos_sel = in_s2.pos[1];
            end
            aoc_pkg::AXIS_Z: begin
                ov_sel  = in_s2.ov[2];
                pos_sel = in_s2.pos[2];
            end
            default: begin
                ov_sel  = in_s2.ov[0];
                pos_sel = in_s2.pos[0];
            end
        endcase
        for (int k = 0; k < 3; k++) begin
            face = pos_sel ? in_s2.hi_a[k] : in_s2.lo_a[k];
            cval = (aoc_pkg::AXIS_W'(k) == axis_sel) ? face
                                                     : aoc_pkg::BOUND_W'($signed(in_s2.ca[k]));
            contact_next[k] = in_s2.hit ? COORD_BITS'(cval) : '0;
        end
        if (in_s2.hit) begin
            res_next.hit   = 1'b1;
            res_next.depth = ov_sel[aoc_pkg::DEPTH_W-1:0];
            res_next.axis  = axis_sel;
            res_next.neg   = !pos_sel;
        end else begin
            res_next.hit   = 1'b0;
            res_next.depth = '0;
            res_next.axis  = aoc_pkg::AXIS_X;
            res_next.neg   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            res_reg <= res_next;
            for (int k = 0; k < 3; k++) begin
                contact_reg[k] <= contact_next[k];
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/aabb_overlap_contact_core.sv @@
// Top level: box-versus-box overlap test with minimum-penetration contact.
// Stages from input transaction to result on m_axis: bounds, overlap, select, each registered.
// Throughput: one box pair per cycle while m_axis is not stalled; each stage holds one transaction and
// refills as soon as its successor takes data, so bubbles collapse under stall.
// Reset: aresetn synchronous, active low; clears all stage valid bits only.
`default_nettype none

module aabb_overlap_contact_core #(
    // wrap width for the contact coordinates (16..48)
    parameter int COORD_BITS = aoc_pkg::COORD_BITS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,

    // Box pair in. tdata, low bit up: center_a_x, center_a_y, center_a_z,
    // size_a_x, size_a_y, size_a_z, center_b_x, center_b_y, center_b_z,
    // size_b_x, size_b_y, size_b_z (31 bits each), zero pad
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [aoc_pkg::S_TDATA_W-1:0]   s_axis_tdata,

    // Contact out. tdata, low bit up: penetration_depth (31), normal_axis (2),
    // normal_negative (1), contact_x, contact_y, contact_z (32 each), zero pad
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [aoc_pkg::M_TDATA_W-1:0]        m_axis_tdata,
    // tuser: hit
    output logic                                 m_axis_tuser
);

    localparam int FW = aoc_pkg::COORD_W;

    aoc_pkg::box_t  box;
    aoc_pkg::s1_t   s1;
    aoc_pkg::s2_t   s2;
    aoc_pkg::res_t  res;
    logic           s1_valid, s1_ready;
    logic           s2_valid, s2_ready;
    logic signed [aoc_pkg::CONTACT_W-1:0] contact_x, contact_y, contact_z;

    // Unpack the input transaction
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            box.ca[k] = s_axis_tdata[k * FW +: FW];
            box.sa[k] = s_axis_tdata[(3 + k) * FW +: FW];
            box.cb[k] = s_axis_tdata[(6 + k) * FW +: FW];
            box.sb[k] = s_axis_tdata[(9 + k) * FW +: FW];
        end
    end

    // Stage 1: min/max faces, 33-bit adds
    aoc_bounds u_bounds (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_box    (box),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_s1    (s1)
    );

    // Stage 2: per-axis overlap test, cross distances and their minimum
    aoc_overlap u_overlap (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_s1     (s1),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_s2    (s2)
    );

    // Stage 3: least-overlap axis, contact point; doubles as output register
    aoc_select #(
        .COORD_BITS (COORD_BITS)
    ) u_select (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .in_s2     (s2),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (res),
        .contact_x (contact_x),
        .contact_y (contact_y),
        .contact_z (contact_z)
    );

    // Pack the result transaction; a miss already carries all zeros
    assign m_axis_tuser = res.hit;
    assign m_axis_tdata = {
        {(aoc_pkg::M_TDATA_W - aoc_pkg::OUT_USED_W){1'b0}},
        contact_z,
        contact_y,
        contact_x,
        res.neg,
        res.axis,
        res.depth
    };

endmodule

`default_nettype wire

@@ hw/rtl/aoc_checker.sv @@
// Port-level assertions for the box overlap contact core, bound to the top level.
`default_nettype none

module aoc_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          m_axis_tvalid,
    input wire logic                          m_axis_tready,
    input wire logic [aoc_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input wire logic                          m_axis_tuser
);

    localparam int AXIS_LSB = aoc_pkg::DEPTH_W;

    // a miss carries no depth, axis, sign or contact
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("miss result with nonzero payload");

    // a hit names a real axis
    a_axis_code: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser) |->
        (m_axis_tdata[AXIS_LSB +: aoc_pkg::AXIS_W] != 2'd3))
        else $error("hit with undefined normal axis");

    // pad bits above the packed fields stay zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |->
        (m_axis_tdata[aoc_pkg::M_TDATA_W-1:aoc_pkg::OUT_USED_W] == '0))
        else $error("nonzero tdata pad");

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind aabb_overlap_contact_core aoc_checker u_aoc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

@@ verif/aabb_overlap_contact_core_tb.sv @@
// Self-checking stream testbench for the box overlap contact core.
module aabb_overlap_contact_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_BITS = aoc_pkg::COORD_BITS_DEF;
    localparam int S_W = aoc_pkg::S_TDATA_W;
    localparam int M_W = aoc_pkg::M_TDATA_W;
    localparam int FW  = aoc_pkg::COORD_W;  // every input field is 31 bits wide
    localparam int DEPTH_W    = aoc_pkg::DEPTH_W;
    localparam int AXIS_W     = aoc_pkg::AXIS_W;
    localparam int CONTACT_W  = aoc_pkg::CONTACT_W;
    localparam int OUT_USED_W = aoc_pkg::OUT_USED_W;

    typedef aoc_pkg::axis_t axis_t;

    // result tdata bit offsets, low bit up
    localparam int AXIS_LSB = DEPTH_W;
    localparam int NEG_BIT  = DEPTH_W + AXIS_W;
    localparam int CX_LSB   = NEG_BIT + 1;
    localparam int CY_LSB   = CX_LSB + CONTACT_W;
    localparam int CZ_LSB   = CY_LSB + CONTACT_W;

    // Q15.16 landmarks for the directed transactions
    localparam longint ONE    = 64'sd65536;
    localparam longint MIN_C  = -(64'sd1 <<< 30);
    localparam longint MAX_C  = (64'sd1 <<< 30) - 1;
    localparam longint MAX_S  = (64'sd1 <<< 31) - 1;   // widest 31-bit size
    localparam longint LIM_S  = 64'sd1 <<< 30;         // widest in-range size

    typedef longint vec3_t [3];

    // expected result, one per accepted box pair
    typedef struct packed {
        logic               hit;
        logic [DEPTH_W-1:0] depth;
        axis_t              axis;
        logic               neg;
        logic [31:0]        cx;
        logic [31:0]        cy;
        logic [31:0]        cz;
    } contact_t;

    logic           aclk = 1'b0;
    logic           aresetn = 1'b0;

    logic           s_axis_tvalid = 1'b0;
    logic           s_axis_tready;
    // center_a_x, center_a_y, center_a_z, size_a_x, size_a_y, size_a_z,
    // center_b_x, center_b_y, center_b_z, size_b_x, size_b_y, size_b_z, zero pad
    logic [S_W-1:0] s_axis_tdata = '0;

    logic           m_axis_tvalid;
    logic           m_axis_tready = 1'b0;
    // penetration_depth, normal_axis, normal_negative, contact_x, contact_y,
    // contact_z, zero pad
    logic [M_W-1:0] m_axis_tdata;
    logic           m_axis_tuser;     // hit

    logic [S_W-1:0] pairs_waiting [$];    // box pairs not yet offered
    contact_t       contacts_due [$];     // predictions, oldest first
    int             mismatch_count = 0;
    int             idle_pct = 0;         // sender idle chance, percent
    int             stall_pct = 0;        // receiver stall chance, percent
    bit             hold_input = 1'b0;    // sender pause until drained

    aabb_overlap_contact_core #(
        .COORD_BITS(COORD_BITS)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Box-versus-box contact: bounds from floor half sizes, inclusive overlap
    // on all axes, least overlap picks the axis with X then Y winning ties.
    function automatic contact_t box_contact(input logic [S_W-1:0] d);
        longint ca[3], cb[3], lo_a[3], hi_a[3], lo_b[3], hi_b[3], ov[3];
        longint half_a, half_b, d1, d2, c;
        logic [31:0] cc[3];
        int k, ax;
        bit overlap, b_above;
        contact_t r;
        r = '0;
        overlap = 1'b1;
        for (k = 0; k < 3; k++) begin
            ca[k]   = $signed(d[FW*k +: FW]);
            half_a  = d[FW*(3+k) +: FW] >> 1;
            cb[k]   = $signed(d[FW*(6+k) +: FW]);
            half_b  = d[FW*(9+k) +: FW] >> 1;
            lo_a[k] = ca[k] - half_a;
            hi_a[k] = ca[k] + half_a;
            lo_b[k] = cb[k] - half_b;
            hi_b[k] = cb[k] + half_b;
            if (lo_a[k] > hi_b[k] || hi_a[k] < lo_b[k])
                overlap = 1'b0;
            d1 = hi_a[k] - lo_b[k];
            d2 = hi_b[k] - lo_a[k];
            ov[k] = (d1 < d2) ? d1 : d2;
        end
        if (!overlap)
            return r;      // a miss zeroes every field
        ax = 0;
        if (ov[1] < ov[ax])
            ax = 1;
        if (ov[2] < ov[ax])
            ax = 2;
        // normal is positive only when B's center is strictly above A's
        b_above = cb[ax] > ca[ax];
        for (k = 0; k < 3; k++) begin
            c = ca[k];
            if (k == ax)
                c = b_above ? hi_a[k] : lo_a[k];
            c = (c <<< (64 - COORD_BITS)) >>> (64 - COORD_BITS);
            cc[k] = c[31:0];
        end
        r.hit   = 1'b1;
        r.depth = DEPTH_W'(ov[ax]);
        r.axis  = axis_t'(ax);
        r.neg   = !b_above;
        r.cx    = cc[0];
        r.cy    = cc[1];
        r.cz    = cc[2];
        return r;
    endfunction

    task automatic push_boxes(input vec3_t ca, input vec3_t sa,
                              input vec3_t cb, input vec3_t sb);
        logic [S_W-1:0] d;
        int k;
        d = '0;
        for (k = 0; k < 3; k++) begin
            d[FW*k     +: FW] = FW'(ca[k]);
            d[FW*(3+k) +: FW] = FW'(sa[k]);
            d[FW*(6+k) +: FW] = FW'(cb[k]);
            d[FW*(9+k) +: FW] = FW'(sb[k]);
        end
        pairs_waiting.push_back(d);
    endtask

    function automatic longint any_center();
        logic [FW-1:0] r;
        r = FW'($urandom);
        return $signed(r);
    endfunction

    function automatic longint any_size();
        case ($urandom_range(7))
            0: return 0;
            1: return MAX_S;
            2: return LIM_S;
            3: return $urandom_range(64 * 65536);
            default: return FW'($urandom);
        endcase
    endfunction

    // Mostly boxes placed to touch or overlap, with random geometry; some
    // pushed just clear on one axis; the rest unrelated boxes over the whole
    // field range, which covers the wide sizes and the high bits.
    task automatic push_random_pair();
        vec3_t ca, sa, cb, sb, delta;
        longint reach, off;
        int mode, gap_axis, tie_axis, k;
        mode     = $urandom_range(99);
        gap_axis = $urandom_range(2);
        tie_axis = $urandom_range(1, 2);
        for (k = 0; k < 3; k++) begin
            if (mode < 80) begin
                if ($urandom_range(3) == 0)
                    ca[k] = any_center();
                else
                    ca[k] = longint'($urandom_range(1 << 27)) - (1 << 26);
                case ($urandom_range(5))
                    0: sa[k] = 0;
                    1: sa[k] = $urandom_range(7);
                    default: sa[k] = $urandom_range(1 << 27);
                endcase
                sb[k] = ($urandom_range(5) == 0) ? $urandom_range(7) : $urandom_range(1 << 27);
                reach = (sa[k] >> 1) + (sb[k] >> 1);
                case ($urandom_range(7))
                    0: off = 0;
                    1: off = reach;                 // faces touching
                    default: off = $urandom_range(reach);
                endcase
                if (mode >= 70 && k == gap_axis)
                    off = reach + 1 + $urandom_range(ONE);   // just clear
                delta[k] = $urandom_range(1) ? off : -off;
            end else begin
                ca[k] = any_center();
                sa[k] = any_size();
                cb[k] = any_center();
                sb[k] = any_size();
            end
        end
        if (mode < 80) begin
            // copy X geometry onto another axis now and then to force ties
            if (mode < 70 && $urandom_range(4) == 0) begin
                sa[tie_axis]    = sa[0];
                sb[tie_axis]    = sb[0];
                delta[tie_axis] = delta[0];
            end
            for (k = 0; k < 3; k++) begin
                cb[k] = ca[k] + delta[k];
                if (cb[k] > MAX_C || cb[k] < MIN_C)
                    cb[k] = ca[k] - delta[k];
            end
        end
        push_boxes(ca, sa, cb, sb);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mismatch in %s: expected %h, got %h", name, want, got);
        end
    endtask

    // Driver: records the prediction for each accepted transaction, then
    // offers the next pending pair unless idling or held off.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                contacts_due.push_back(box_contact(s_axis_tdata));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (!hold_input && pairs_waiting.size() != 0 &&
                        $urandom_range(99) >= idle_pct) begin
                    s_axis_tdata  <= pairs_waiting.pop_front();
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: every accepted result is checked against the oldest prediction,
    // field by field, including the zero pad above the contact point.
    always @(posedge aclk) begin
        contact_t want;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (contacts_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result transaction: tuser %b tdata %h",
                                 m_axis_tuser, m_axis_tdata);
                end else begin
                    want = contacts_due.pop_front();
                    check_field("hit", want.hit, m_axis_tuser);
                    check_field("penetration_depth", want.depth, m_axis_tdata[DEPTH_W-1:0]);
                    check_field("normal_axis", want.axis, m_axis_tdata[AXIS_LSB +: AXIS_W]);
                    check_field("normal_negative", want.neg, m_axis_tdata[NEG_BIT]);
                    check_field("contact_x", want.cx, m_axis_tdata[CX_LSB +: CONTACT_W]);
                    check_field("contact_y", want.cy, m_axis_tdata[CY_LSB +: CONTACT_W]);
                    check_field("contact_z", want.cz, m_axis_tdata[CZ_LSB +: CONTACT_W]);
                    check_field("tdata pad", 64'd0, m_axis_tdata[M_W-1:OUT_USED_W]);
                end
            end
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Run limit: far above the slowest legal run.
    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        int phase, k;
        int idle_by_phase[4];
        int stall_by_phase[4];
        vec3_t ca, sa, cb, sb;
        idle_by_phase  = '{0, 72, 0, 31};
        stall_by_phase = '{0, 0, 72, 31};

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // degenerate boxes: zero size at the origin, touching everywhere
        push_boxes('{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0});
        // both boxes pinned at the most negative center
        push_boxes('{MIN_C, MIN_C, MIN_C}, '{0, 0, 0}, '{MIN_C, MIN_C, MIN_C}, '{0, 0, 0});
        // most positive centers with the widest sizes
        push_boxes('{MAX_C, MAX_C, MAX_C}, '{MAX_S, MAX_S, MAX_S},
                   '{MAX_C, MAX_C, MAX_C}, '{MAX_S, MAX_S, MAX_S});
        // opposite corners: miss on every axis
        push_boxes('{MIN_C, MIN_C, MIN_C}, '{0, 0, 0}, '{MAX_C, MAX_C, MAX_C}, '{0, 0, 0});
        // widest sizes at opposite extremes on X: clear by one LSB
        push_boxes('{MIN_C, 0, 0}, '{MAX_S, MAX_S, MAX_S},
                   '{MAX_C, 0, 0}, '{MAX_S, MAX_S, MAX_S});
        // widest in-range sizes, faces meeting at zero on X
        push_boxes('{-(LIM_S >> 1), 0, 0}, '{LIM_S, LIM_S, LIM_S},
                   '{LIM_S >> 1, 0, 0}, '{LIM_S, LIM_S, LIM_S});
        // X wide overlap: A at top, B near bottom, depth one LSB on X
        push_boxes('{MAX_C, 0, 0}, '{MAX_S, MAX_S, MAX_S},
                   '{MIN_C + 2, 0, 0}, '{MAX_S, MAX_S, MAX_S});
        // per axis: least overlap with B above, with B below, and clear by one LSB
        for (k = 0; k < 3; k++) begin
            ca = '{0, 0, 0};
            sa = '{8 * ONE, 8 * ONE, 8 * ONE};
            sb = sa;
            sa[k] = 4 * ONE;
            sb[k] = 4 * ONE;
            cb = ca;
            cb[k] = 3 * ONE;
            push_boxes(ca, sa, cb, sb);
            cb[k] = -3 * ONE;
            push_boxes(ca, sa, cb, sb);
            cb[k] = 4 * ONE + 1;
            push_boxes(ca, sa, cb, sb);
        end
        // equal overlap on X and Y: X wins
        push_boxes('{0, 0, 0}, '{4 * ONE, 4 * ONE, 8 * ONE},
                   '{ONE, ONE, 0}, '{4 * ONE, 4 * ONE, 8 * ONE});
        // equal overlap on Y and Z: Y wins
        push_boxes('{0, 0, 0}, '{8 * ONE, 4 * ONE, 4 * ONE},
                   '{0, ONE, ONE}, '{8 * ONE, 4 * ONE, 4 * ONE});
        // equal centers, least overlap on Z: normal negative, min face
        push_boxes('{5 * ONE, -7 * ONE, 3 * ONE}, '{8 * ONE, 8 * ONE, 2 * ONE},
                   '{5 * ONE, -7 * ONE, 3 * ONE}, '{8 * ONE, 8 * ONE, 4 * ONE});
        // odd raw sizes: halving floors
        push_boxes('{0, 0, 0}, '{3, 5, 7}, '{1, -1, 1}, '{1, 2, 3});
        // A wholly inside B
        push_boxes('{ONE, ONE, ONE}, '{2 * ONE, 2 * ONE, 2 * ONE},
                   '{0, 0, 0}, '{LIM_S, LIM_S, LIM_S});

        for (phase = 0; phase < 4; phase++) begin
            idle_pct  = idle_by_phase[phase];
            stall_pct = stall_by_phase[phase];
            repeat (225) push_random_pair();
            if (phase == 1) begin
                // sender holds off midway until the pipe has fully drained
                while (pairs_waiting.size() > 110)
                    @(negedge aclk);
                hold_input = 1'b1;
                while (s_axis_tvalid || contacts_due.size() != 0)
                    @(negedge aclk);
                hold_input = 1'b0;
            end
            while (pairs_waiting.size() != 0 || s_axis_tvalid || contacts_due.size() != 0)
                @(negedge aclk);
        end

        // three-stage pipe: allow well past its latency for stray results
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
